// File: hw/rtl/cbc_pkg.sv
// Shared types and constants of the cartridge bank controller.
// No dependencies; imported by every controller module except the RAM.
package cbc_pkg;

    // External RAM geometry
    localparam int unsigned RAM_BANKS_DEF = 4;
    localparam int unsigned BANK_BYTES    = 8192;
    localparam int unsigned OFFSET_W      = $clog2(BANK_BYTES);
    localparam int unsigned BANK_SEL_W    = 2;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_CONTROLLER_KIND = 1'b0,
        REG_RAM_PRESENT     = 1'b1
    } cfg_reg_t;

    // Controller kinds
    localparam logic KIND_MBC1 = 1'b0;
    localparam logic KIND_MBC3 = 1'b1;

    // Bus regions, decoded from address bits 15:13
    localparam logic [2:0] REGION_ENABLE   = 3'd0;
    localparam logic [2:0] REGION_ROM_BANK = 3'd1;
    localparam logic [2:0] REGION_UPPER    = 3'd2;
    localparam logic [2:0] REGION_MODE     = 3'd3;
    localparam logic [2:0] REGION_RAM      = 3'd5;

    // RAM enable keys
    localparam logic [7:0] RAM_ENABLE_KEY  = 8'h0A;
    localparam logic [7:0] RAM_DISABLE_KEY = 8'h00;

    // Decoded access from the bank registers
    typedef struct packed {
        logic       ram_wr;
        logic       ram_rd;
        logic       claimed;
        logic       bank_set;
        logic [6:0] rom_bank;
    } access_t;

    // Result fields waiting for the RAM read data
    typedef struct packed {
        logic       rd;
        logic       claimed;
        logic       bank_set;
        logic [6:0] rom_bank;
    } result_t;

endpackage

// File: hw/rtl/cartridge_bank_controller_top.sv
// Cartridge bank controller, MBC1 and MBC3 rules, top level.
// Result path: an accepted item passes the stage register, then the output register.
// Throughput: one item per cycle unless m_ready stalls (single RAM port, one access each).
// Reset: control registers clear at once; the external RAM is then swept to zero,
// all RAM_BANKS * 8192 bytes (32768 by default), with s_ready low; config writes still taken.
// Depends on cbc_pkg, cbc_ram, cbc_bank_regs and cbc_out_stage.
module cartridge_bank_controller_top import cbc_pkg::*; #(
    parameter int unsigned RAM_BANKS = RAM_BANKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [6:0]  m_rom_bank,
    output logic        m_rom_bank_set,
    output logic        m_claimed
);

    localparam int unsigned DEPTH  = RAM_BANKS * BANK_BYTES;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    logic                         clear_busy_reg, clear_busy_next;
    logic [ADDR_W-1:0]            clear_addr_reg, clear_addr_next;
    logic                         accept;
    logic                         out_free;
    access_t                      access;
    result_t                      result;
    logic [1:0]                   ram_bank;
    logic [BANK_SEL_W+OFFSET_W-1:0] item_addr_full;
    logic                         ram_we;
    logic                         ram_re;
    logic [ADDR_W-1:0]            ram_addr;
    logic [7:0]                   ram_wdata;
    logic [7:0]                   ram_rdata;

    // Reduce the RAM bank register to the banks fitted
    function automatic logic [1:0] fold_bank(input logic [1:0] bank);
        logic [2:0] v;
        v = {1'b0, bank};
        for (int i = 0; i < 3; i++) begin
            if (v >= 3'(RAM_BANKS)) begin
                v = v - 3'(RAM_BANKS);
            end
        end
        return v[1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = !clear_busy_reg && out_free;
    assign accept    = s_valid && s_ready;

    cbc_bank_regs u_bank_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .command    (s_command),
        .address    (s_address),
        .write_data (s_write_data),
        .access     (access),
        .ram_bank   (ram_bank)
    );

    // Sweep the RAM to zero after reset
    always_comb begin
        clear_busy_next = clear_busy_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_busy_reg) begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clear_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end else begin
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    // Select the RAM port between the sweep and item accesses
    always_comb begin
        item_addr_full = {fold_bank(ram_bank), s_address[OFFSET_W-1:0]};
        ram_we         = clear_busy_reg || access.ram_wr;
        ram_re         = access.ram_rd;
        ram_addr       = clear_busy_reg ? clear_addr_reg : item_addr_full[ADDR_W-1:0];
        ram_wdata      = clear_busy_reg ? 8'd0 : s_write_data;
    end

    cbc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign result.rd       = access.ram_rd;
    assign result.claimed  = access.claimed;
    assign result.bank_set = access.bank_set;
    assign result.rom_bank = access.rom_bank;

    cbc_out_stage u_out_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (accept),
        .result         (result),
        .ram_rdata      (ram_rdata),
        .free           (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_rom_bank     (m_rom_bank),
        .m_rom_bank_set (m_rom_bank_set),
        .m_claimed      (m_claimed)
    );

    // No item enters while the RAM sweep runs
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy_reg |-> !s_ready)
        else $error("item accepted during RAM clear");

    // The mapped ROM bank is never zero
    a_rom_bank_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rom_bank != 7'd0))
        else $error("ROM bank zero in result");

    // Only a claimed read returns RAM data
    a_data_needs_claim: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_read_data != 8'd0)) |-> m_claimed)
        else $error("read data on unclaimed item");

    // A bank select is always a claimed write
    a_bank_set_claimed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rom_bank_set) |-> m_claimed)
        else $error("bank set on unclaimed item");

endmodule

// File: hw/rtl/cbc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module cbc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read at one address; hold read data between reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/cbc_bank_regs.sv
// Bank control registers, configuration registers and access decode.
// Depends on cbc_pkg.
module cbc_bank_regs import cbc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        accept,
    input  logic        command,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    output access_t     access,
    output logic [1:0]  ram_bank
);

    logic       kind_reg,     kind_next;
    logic       present_reg,  present_next;
    logic       ram_on_reg,   ram_on_next;
    logic [1:0] upper_reg,    upper_next;
    logic       mode_reg,     mode_next;
    logic [1:0] ram_bank_reg, ram_bank_next;
    logic [6:0] rom_bank_reg, rom_bank_next;

    logic [2:0] region;
    logic       in_window;
    logic       ram_ok;
    logic [6:0] mbc1_raw;
    logic [6:0] mbc1_bank;
    logic [6:0] mbc3_bank;

    // Bank candidates for a write to the ROM bank region
    always_comb begin
        region    = address[15:13];
        in_window = (region == REGION_RAM);
        ram_ok    = present_reg && ram_on_reg;
        mbc1_raw  = {(mode_reg ? 2'b00 : upper_reg), write_data[4:0]};
        mbc1_bank = (write_data[4:0] == 5'd0) ? mbc1_raw + 7'd1 : mbc1_raw;
        mbc3_bank = (write_data[6:0] == 7'd0) ? 7'd1 : write_data[6:0];
    end

    // Configuration writes
    always_comb begin
        kind_next    = kind_reg;
        present_next = present_reg;
        if (cfg_write) begin
            case (cfg_reg_t'(cfg_index))
                REG_CONTROLLER_KIND: kind_next    = cfg_data;
                REG_RAM_PRESENT:     present_next = cfg_data;
                default: ;
            endcase
        end
    end

    // Decode one accepted item
    always_comb begin
        ram_on_next     = ram_on_reg;
        upper_next      = upper_reg;
        mode_next       = mode_reg;
        ram_bank_next   = ram_bank_reg;
        rom_bank_next   = rom_bank_reg;
        access.ram_wr   = 1'b0;
        access.ram_rd   = 1'b0;
        access.claimed  = 1'b0;
        access.bank_set = 1'b0;
        if (accept) begin
            if (!command) begin
                if (in_window && ram_ok) begin
                    access.ram_rd  = 1'b1;
                    access.claimed = 1'b1;
                end
            end else if (!address[15]) begin
                access.claimed = 1'b1;
                case (region)
                    REGION_ENABLE: begin
                        if (write_data == RAM_ENABLE_KEY) begin
                            ram_on_next = 1'b1;
                        end else if (write_data == RAM_DISABLE_KEY) begin
                            ram_on_next = 1'b0;
                        end
                    end
                    REGION_ROM_BANK: begin
                        rom_bank_next   = (kind_reg == KIND_MBC3) ? mbc3_bank : mbc1_bank;
                        access.bank_set = 1'b1;
                    end
                    REGION_UPPER: begin
                        if (kind_reg == KIND_MBC1) begin
                            if (!mode_reg) begin
                                upper_next = write_data[1:0];
                            end else begin
                                ram_bank_next = write_data[1:0];
                            end
                        end else if (write_data[7:2] == 6'd0) begin
                            ram_bank_next = write_data[1:0];
                        end
                    end
                    REGION_MODE: begin
                        if (kind_reg == KIND_MBC1) begin
                            mode_next = write_data[0];
                        end
                    end
                    default: ;
                endcase
            end else if (in_window && ram_ok) begin
                access.ram_wr  = 1'b1;
                access.claimed = 1'b1;
            end
        end
        access.rom_bank = rom_bank_next;
    end

    // Advance the register state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= KIND_MBC1;
            present_reg  <= 1'b0;
            ram_on_reg   <= 1'b0;
            upper_reg    <= 2'd0;
            mode_reg     <= 1'b0;
            ram_bank_reg <= 2'd0;
            rom_bank_reg <= 7'd1;
        end else begin
            kind_reg     <= kind_next;
            present_reg  <= present_next;
            ram_on_reg   <= ram_on_next;
            upper_reg    <= upper_next;
            mode_reg     <= mode_next;
            ram_bank_reg <= ram_bank_next;
            rom_bank_reg <= rom_bank_next;
        end
    end

    assign ram_bank = ram_bank_reg;

endmodule

// File: hw/rtl/cbc_out_stage.sv
// Result stage and output register with skid behavior toward the result channel.
// Depends on cbc_pkg.
module cbc_out_stage import cbc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  result_t    result,
    input  logic [7:0] ram_rdata,
    output logic       free,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic [6:0] m_rom_bank,
    output logic       m_rom_bank_set,
    output logic       m_claimed
);

    logic       s1_valid_reg, s1_valid_next;
    result_t    s1_reg;
    logic       o_valid_reg,  o_valid_next;
    logic [7:0] o_read_data_reg;
    logic [6:0] o_rom_bank_reg;
    logic       o_bank_set_reg;
    logic       o_claimed_reg;
    logic       s1_move;

    // Move the waiting item forward when the output register frees up
    always_comb begin
        s1_move       = s1_valid_reg && (!o_valid_reg || m_ready);
        free          = !s1_valid_reg || s1_move;
        s1_valid_next = load ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        o_valid_next  = s1_move ? 1'b1 : (m_ready ? 1'b0 : o_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    // Hold payloads; merge RAM read data on the way out
    always_ff @(posedge aclk) begin
        if (load) begin
            s1_reg <= result;
        end
        if (s1_move) begin
            o_read_data_reg <= s1_reg.rd ? ram_rdata : 8'd0;
            o_rom_bank_reg  <= s1_reg.rom_bank;
            o_bank_set_reg  <= s1_reg.bank_set;
            o_claimed_reg   <= s1_reg.claimed;
        end
    end

    assign m_valid        = o_valid_reg;
    assign m_read_data    = o_read_data_reg;
    assign m_rom_bank     = o_rom_bank_reg;
    assign m_rom_bank_set = o_bank_set_reg;
    assign m_claimed      = o_claimed_reg;

endmodule
